// File: rtl/core/iac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iac_pkg
// Types, codes and helpers shared by the IPv4 address classifier.
// ----------------------------------------------------------------------------
package iac_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int IFACES_DEF  = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] FS_NET        = 3'd0;
	localparam logic [2:0] FS_NETMASK    = 3'd1;
	localparam logic [2:0] FS_SUBNET     = 3'd2;
	localparam logic [2:0] FS_SUBNETMASK = 3'd3;
	localparam logic [2:0] FS_BCAST      = 3'd4;
	localparam logic [2:0] FS_NETBCAST   = 3'd5;
	localparam logic [2:0] FS_IFACE      = 3'd6;
	localparam logic [2:0] FS_VALID      = 3'd7;

	typedef struct packed {
		logic        op;
		logic [2:0]  entry_index;
		logic [2:0]  field_select;
		logic [31:0] write_value;
		logic [31:0] address;
		logic [2:0]  iface_id;
		logic        iface_can_broadcast;
	} in_item_t;

	typedef struct packed {
		logic [31:0] net_number;
		logic        is_local;
		logic        can_forward;
		logic        is_broadcast;
		logic        write_done;
	} out_item_t;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] netmask;
		logic [31:0] subnet;
		logic [31:0] subnetmask;
		logic [31:0] bcast;
		logic [31:0] net_bcast;
		logic [2:0]  iface;
	} entry_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] class_net;
		logic        is_class_e;
		logic [2:0]  iface_id;
		logic        can_bcast;
		logic        subnets_local;
	} query_ctx_t;

	typedef struct packed {
		logic [31:0] net_number;
		logic        is_local;
		logic        is_broadcast;
	} match_res_t;

	function automatic logic [31:0] class_net_of(input logic [31:0] a);
		logic [31:0] r;
		if (!a[31])
			r = a & 32'hFF00_0000;
		else if (a[31:30] == 2'b10)
			r = a & 32'hFFFF_0000;
		else if (a[31:29] == 3'b110)
			r = a & 32'hFFFF_FF00;
		else if (a[31:28] == 4'b1110)
			r = a & 32'hF000_0000;
		else
			r = 32'd0;
		return r;
	endfunction

	function automatic logic forward_of(input logic [31:0] a);
		logic r;
		r = 1'b1;
		if (a[31:29] == 3'b111)
			r = 1'b0;
		else if (!a[31] && (a[31:24] == 8'h00 || a[31:24] == 8'h7F))
			r = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/ipv4_address_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_address_classifier
// Classful IPv4 address classifier over a table of interface addresses.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A write item updates one field of one
// table entry, and its acknowledge is loaded into the output register from
// the put state. A query reads the table through a single memory read port,
// one entry per cycle in index order, then passes the last and put states
// before its result is registered; the next item is taken only back in the
// idle state. Results sit in an output register, and an item can be taken
// while the previous result still waits. Valid bits clear at reset; no
// other table initialization is done.
// ----------------------------------------------------------------------------
module ipv4_address_classifier
	import iac_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IFACES  = IFACES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [6:0] ENTRIES_W = 7'(ENTRIES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic             is_write_q;
	logic             subnets_local_q;
	logic             valid_q [ENTRIES];
	logic             rd_vld_s1;
	logic             ent_valid_s1;
	query_ctx_t       ctx_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             accept;
	logic             wr_ok;
	logic             ram_we;
	logic [IDX_W-1:0] waddr;
	logic             scan_rd;
	logic             out_load;
	entry_t           ent_s1;
	match_res_t       mres;
	out_item_t        result;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign wr_ok     = ({4'd0, in_data.entry_index} < ENTRIES_W);
	assign waddr     = IDX_W'(in_data.entry_index);
	assign ram_we    = accept && (in_data.op == OP_WRITE) && wr_ok &&
		(in_data.field_select != FS_VALID);
	assign scan_rd   = (state_q == ST_SCAN);
	assign out_load  = (state_q == ST_PUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subnets_local_q <= 1'b1;
		end else if (cfg_we) begin
			subnets_local_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				valid_q[i] <= 1'b0;
		end else if (accept && in_data.op == OP_WRITE && wr_ok &&
				in_data.field_select == FS_VALID) begin
			valid_q[waddr] <= in_data.write_value[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			is_write_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_rd;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q      <= '0;
						is_write_q <= (in_data.op == OP_WRITE);
						state_q    <= (in_data.op == OP_WRITE) ? ST_PUT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX)
						state_q <= ST_LAST;
					else
						idx_q <= idx_q + 1'b1;
				end
				ST_LAST: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			ent_valid_s1 <= valid_q[idx_q];
		end
		if (accept) begin
			ctx_q.address       <= in_data.address;
			ctx_q.class_net     <= class_net_of(in_data.address);
			ctx_q.is_class_e    <= (in_data.address[31:28] == 4'b1111);
			ctx_q.iface_id      <= in_data.iface_id;
			ctx_q.can_bcast     <= in_data.iface_can_broadcast;
			ctx_q.subnets_local <= subnets_local_q;
		end
	end

	iac_entry_ram #(
		.ENTRIES(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wsel  (in_data.field_select),
		.wdata (in_data.write_value),
		.re    (scan_rd),
		.raddr (idx_q),
		.rdata (ent_s1)
	);

	iac_match #(
		.IFACES(IFACES)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.en        (rd_vld_s1),
		.ctx       (ctx_q),
		.ent       (ent_s1),
		.ent_valid (ent_valid_s1),
		.res       (mres)
	);

	always_comb begin
		if (is_write_q) begin
			result = '0;
			result.write_done = 1'b1;
		end else begin
			result.net_number   = mres.net_number;
			result.is_local     = mres.is_local;
			result.can_forward  = forward_of(ctx_q.address);
			result.is_broadcast = mres.is_broadcast;
			result.write_done   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/iac_entry_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iac_entry_ram
// Interface address table: one entry per word, field-wise write enables,
// one registered read port.
// ----------------------------------------------------------------------------
module iac_entry_ram
	import iac_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire logic [2:0]       wsel,
	input  wire logic [31:0]      wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			case (wsel)
				FS_NET:        mem[waddr].net        <= wdata;
				FS_NETMASK:    mem[waddr].netmask    <= wdata;
				FS_SUBNET:     mem[waddr].subnet     <= wdata;
				FS_SUBNETMASK: mem[waddr].subnetmask <= wdata;
				FS_BCAST:      mem[waddr].bcast      <= wdata;
				FS_NETBCAST:   mem[waddr].net_bcast  <= wdata;
				FS_IFACE:      mem[waddr].iface      <= wdata[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/iac_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iac_match
// Per-entry compare and accumulate for one query: first net match,
// local membership and interface broadcast hit.
// ----------------------------------------------------------------------------
module iac_match
	import iac_pkg::*;
#(
	parameter int IFACES = IFACES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic clear,
	input  wire logic en,
	input  query_ctx_t ctx,
	input  entry_t     ent,
	input  wire logic  ent_valid,
	output match_res_t res
);

	localparam logic [6:0] IFACES_W = 7'(IFACES);

	logic        found_q;
	logic [31:0] net_val_q;
	logic        local_q;
	logic        bcast_q;

	logic net_hit;
	logic local_hit;
	logic bcast_hit;
	logic iface_ok;

	always_comb begin
		net_hit = ent_valid && (ent.net == ctx.class_net);
		if (ctx.subnets_local)
			local_hit = ent_valid && ((ctx.address & ent.netmask) == ent.net);
		else
			local_hit = ent_valid && ((ctx.address & ent.subnetmask) == ent.subnet);
		bcast_hit = ent_valid && (ent.iface == ctx.iface_id) &&
			(ctx.address == ent.bcast || ctx.address == ent.net_bcast ||
			 ctx.address == ent.subnet || ctx.address == ent.net);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			local_q <= 1'b0;
			bcast_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
			local_q <= 1'b0;
			bcast_q <= 1'b0;
		end else if (en) begin
			if (net_hit)
				found_q <= 1'b1;
			if (local_hit)
				local_q <= 1'b1;
			if (bcast_hit)
				bcast_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && net_hit && !found_q) begin
			net_val_q <= ctx.address & ent.subnetmask;
		end
	end

	always_comb begin
		iface_ok = {4'd0, ctx.iface_id} < IFACES_W;
		if (ctx.is_class_e)
			res.net_number = 32'd0;
		else if (found_q)
			res.net_number = net_val_q;
		else
			res.net_number = ctx.class_net;
		res.is_local = local_q;
		res.is_broadcast = (ctx.address == 32'hFFFF_FFFF) || (ctx.address == 32'd0) ||
			(ctx.can_bcast && iface_ok && bcast_q);
	end

endmodule
`default_nettype wire

// File: tb/ipv4_address_classifier_tb.sv
// ----------------------------------------------------------------------------
// ipv4_address_classifier_tb
// Self-checking bench for the IPv4 address classifier. Table writes and
// address queries are queued in phases, and a clocked driver sends them over
// the valid/ready input. A built-in predictor keeps a shadow table that is
// updated on every accepted input transfer and computes the answer for
// each query. Output transfers are checked in order, field by field. The
// run covers both settings of the subnet-local register, changed only
// while the block is idle, and random gaps on both handshakes.
// ----------------------------------------------------------------------------
module ipv4_address_classifier_tb;
	import iac_pkg::*;

	localparam int N_ENTRIES   = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 200000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;

	in_item_t  requests[$];
	out_item_t pending_answers[$];
	int        queued = 0;
	int        items_taken = 0;
	int        cycles = 0;
	int        errors = 0;

	// predictor state
	logic [31:0] t_net[N_ENTRIES];
	logic [31:0] t_mask[N_ENTRIES];
	logic [31:0] t_sub[N_ENTRIES];
	logic [31:0] t_submask[N_ENTRIES];
	logic [31:0] t_bc[N_ENTRIES];
	logic [31:0] t_nbc[N_ENTRIES];
	logic [2:0]  t_if[N_ENTRIES];
	logic        t_on[N_ENTRIES];
	logic        local_by_net = 1'b1;

	// stimulus-side view of the table, used to aim queries
	logic [31:0] g_net[N_ENTRIES];
	logic [31:0] g_mask[N_ENTRIES];
	logic [31:0] g_sub[N_ENTRIES];
	logic [31:0] g_submask[N_ENTRIES];
	logic [31:0] g_bc[N_ENTRIES];
	logic [31:0] g_nbc[N_ENTRIES];
	logic [2:0]  g_if[N_ENTRIES];
	logic [6:0]  g_written[N_ENTRIES];

	wire calm = items_taken >= 200 && items_taken < 300;

	ipv4_address_classifier #(
		.ENTRIES(N_ENTRIES),
		.IFACES (IFACES_DEF)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		for (int k = 0; k < N_ENTRIES; k++) begin
			t_on[k] = 1'b0;
			g_net[k] = '0;
			g_mask[k] = '0;
			g_sub[k] = '0;
			g_submask[k] = '0;
			g_bc[k] = '0;
			g_nbc[k] = '0;
			g_if[k] = '0;
			g_written[k] = '0;
		end
	end

	function automatic out_item_t classify_item(input in_item_t it);
		out_item_t   r;
		logic [31:0] a;
		logic [31:0] cls;
		logic        is_e;
		logic        found;
		r = '0;
		if (it.op == OP_WRITE) begin
			case (it.field_select)
				FS_NET:        t_net[it.entry_index] = it.write_value;
				FS_NETMASK:    t_mask[it.entry_index] = it.write_value;
				FS_SUBNET:     t_sub[it.entry_index] = it.write_value;
				FS_SUBNETMASK: t_submask[it.entry_index] = it.write_value;
				FS_BCAST:      t_bc[it.entry_index] = it.write_value;
				FS_NETBCAST:   t_nbc[it.entry_index] = it.write_value;
				FS_IFACE:      t_if[it.entry_index] = it.write_value[2:0];
				default:       t_on[it.entry_index] = it.write_value[0];
			endcase
			r.write_done = 1'b1;
			return r;
		end
		a = it.address;
		is_e = 1'b0;
		if (a[31] == 1'b0)
			cls = {a[31:24], 24'h0};
		else if (a[31:30] == 2'b10)
			cls = {a[31:16], 16'h0};
		else if (a[31:29] == 3'b110)
			cls = {a[31:8], 8'h0};
		else if (a[31:28] == 4'b1110)
			cls = {a[31:28], 28'h0};
		else begin
			cls = '0;
			is_e = 1'b1;
		end
		r.net_number = cls;
		found = 1'b0;
		for (int k = 0; k < N_ENTRIES; k++) begin
			if (!is_e && !found && t_on[k] && t_net[k] == cls) begin
				r.net_number = a & t_submask[k];
				found = 1'b1;
			end
			if (t_on[k]) begin
				if (local_by_net ? (a & t_mask[k]) == t_net[k]
				                 : (a & t_submask[k]) == t_sub[k])
					r.is_local = 1'b1;
			end
		end
		r.can_forward = !(a[31:29] == 3'b111 ||
			(!a[31] && (a[31:24] == 8'h00 || a[31:24] == 8'h7F)));
		if (a == 32'hFFFF_FFFF || a == 32'h0)
			r.is_broadcast = 1'b1;
		else if (it.iface_can_broadcast && it.iface_id < IFACES_DEF) begin
			for (int k = 0; k < N_ENTRIES; k++)
				if (t_on[k] && t_if[k] == it.iface_id &&
				    (a == t_bc[k] || a == t_nbc[k] || a == t_sub[k] || a == t_net[k]))
					r.is_broadcast = 1'b1;
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (requests.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
				in_data <= requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || $urandom_range(99) >= 37;
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					$error("result transfer with no answer pending: %p", out_data);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					compare_field("net_number", want.net_number, out_data.net_number);
					compare_field("is_local", 32'(want.is_local),
						32'(out_data.is_local));
					compare_field("can_forward", 32'(want.can_forward),
						32'(out_data.can_forward));
					compare_field("is_broadcast", 32'(want.is_broadcast),
						32'(out_data.is_broadcast));
					compare_field("write_done", 32'(want.write_done),
						32'(out_data.write_done));
				end
			end
			if (in_valid && in_ready) begin
				pending_answers.push_back(classify_item(in_data));
				items_taken <= items_taken + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_write(input logic [2:0] idx, input logic [2:0] sel,
	                          input logic [31:0] val);
		in_item_t it;
		// never mark an entry valid before all of its fields hold data
		if (sel == FS_VALID && g_written[idx] != 7'h7F)
			val[0] = 1'b0;
		it.op = OP_WRITE;
		it.entry_index = idx;
		it.field_select = sel;
		it.write_value = val;
		it.address = $urandom;
		it.iface_id = 3'($urandom_range(7));
		it.iface_can_broadcast = 1'($urandom_range(1));
		case (sel)
			FS_NET:        g_net[idx] = val;
			FS_NETMASK:    g_mask[idx] = val;
			FS_SUBNET:     g_sub[idx] = val;
			FS_SUBNETMASK: g_submask[idx] = val;
			FS_BCAST:      g_bc[idx] = val;
			FS_NETBCAST:   g_nbc[idx] = val;
			FS_IFACE:      g_if[idx] = val[2:0];
			default:       ;
		endcase
		if (sel != FS_VALID)
			g_written[idx][sel] = 1'b1;
		requests.push_back(it);
		queued++;
	endtask

	task automatic push_query(input logic [31:0] a, input logic [2:0] ifc,
	                          input logic can_bc);
		in_item_t it;
		it.op = OP_QUERY;
		it.entry_index = 3'($urandom_range(7));
		it.field_select = 3'($urandom_range(7));
		it.write_value = $urandom;
		it.address = a;
		it.iface_id = ifc;
		it.iface_can_broadcast = can_bc;
		requests.push_back(it);
		queued++;
	endtask

	task automatic program_entry(input logic [2:0] idx, input logic [31:0] net,
	                             input logic [31:0] mask, input logic [31:0] sub,
	                             input logic [31:0] submask, input logic [31:0] bc,
	                             input logic [31:0] nbc, input logic [2:0] ifc);
		push_write(idx, FS_NET, net);
		push_write(idx, FS_NETMASK, mask);
		push_write(idx, FS_SUBNET, sub);
		push_write(idx, FS_SUBNETMASK, submask);
		push_write(idx, FS_BCAST, bc);
		push_write(idx, FS_NETBCAST, nbc);
		push_write(idx, FS_IFACE, ($urandom & ~32'h7) | {29'd0, ifc});
		push_write(idx, FS_VALID, $urandom | 32'h1);
	endtask

	task automatic random_entry(input logic [2:0] idx);
		logic [31:0] r;
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] submask;
		logic [31:0] sub;
		logic [7:0]  a_net;
		int          hb;
		int          s;
		int          k;
		r = $urandom;
		k = $urandom_range(N_ENTRIES - 1);
		if (g_written[k] == 7'h7F && $urandom_range(2) == 0) begin
			// another subnet of a net already in the table
			net = g_net[k];
			mask = g_mask[k];
			hb = (mask == 32'hFF00_0000) ? 24 : (mask == 32'hFFFF_0000) ? 16 : 8;
		end else begin
			case ($urandom_range(2))
				0: begin
					a_net = 8'($urandom_range(1, 126));
					net = {a_net, 24'h0};
					mask = 32'hFF00_0000;
					hb = 24;
				end
				1: begin
					net = {2'b10, r[13:0], 16'h0};
					mask = 32'hFFFF_0000;
					hb = 16;
				end
				default: begin
					net = {3'b110, r[20:0], 8'h0};
					mask = 32'hFFFF_FF00;
					hb = 8;
				end
			endcase
		end
		s = $urandom_range(2, hb);
		submask = ~((32'h1 << s) - 32'h1) | mask;
		sub = net | ($urandom & submask & ~mask);
		program_entry(idx, net, mask, sub, submask, sub | ~submask, net | ~mask,
			3'($urandom_range(7)));
	endtask

	task automatic random_query();
		logic [31:0] a;
		logic [31:0] r;
		logic [2:0]  ifc;
		int          k;
		k = $urandom_range(N_ENTRIES - 1);
		r = $urandom;
		case ($urandom_range(11))
			0: a = g_net[k];
			1: a = g_sub[k];
			2: a = g_bc[k];
			3: a = g_nbc[k];
			4, 5: a = g_sub[k] | (r & ~g_submask[k]);
			6: a = g_net[k] | (r & ~g_mask[k]);
			7, 8: begin
				case ($urandom_range(5))
					0: a = 32'h0;
					1: a = 32'hFFFF_FFFF;
					2: a = {8'h7F, r[23:0]};
					3: a = {8'h00, r[23:0]};
					4: a = {4'hE, r[27:0]};
					default: a = {4'hF, r[27:0]};
				endcase
			end
			default: a = r;
		endcase
		if ($urandom_range(9) < 7)
			ifc = g_if[k];
		else
			ifc = 3'($urandom_range(7));
		push_query(a, ifc, $urandom_range(9) < 8);
	endtask

	task automatic random_phase(input int n);
		int start;
		int roll;
		start = queued;
		while (queued - start < n) begin
			roll = $urandom_range(99);
			if (roll < 10)
				random_entry(3'($urandom_range(7)));
			else if (roll < 15)
				push_write(3'($urandom_range(7)), FS_VALID, $urandom);
			else if (roll < 22)
				push_write(3'($urandom_range(7)), 3'($urandom_range(7)), $urandom);
			else
				random_query();
		end
	endtask

	task automatic drain();
		while (requests.size() != 0 || in_valid || pending_answers.size() != 0)
			@(negedge clk);
		repeat (N_ENTRIES + 4) @(posedge clk);
	endtask

	task automatic set_subnets_local(input logic v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		local_by_net = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: address classes, zero, all ones, loopback
		push_query(32'h0000_0000, 3'd0, 1'b0);
		push_query(32'hFFFF_FFFF, 3'd7, 1'b1);
		push_query(32'h7F00_0001, 3'd1, 1'b1);
		push_query(32'h0A01_0203, 3'd0, 1'b1);
		push_query(32'h8001_0203, 3'd3, 1'b0);
		push_query(32'hC0A8_0101, 3'd2, 1'b1);
		push_query(32'hE000_0001, 3'd4, 1'b1);
		push_query(32'hF000_0001, 3'd5, 1'b1);

		program_entry(3'd0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0180,
			32'hFFFF_FF80, 32'hC0A8_01FF, 32'hC0A8_01FF, 3'd2);
		push_query(32'hC0A8_0185, 3'd2, 1'b1);
		push_query(32'hC0A8_01FF, 3'd2, 1'b1);
		push_query(32'hC0A8_0100, 3'd2, 1'b1);
		push_query(32'hC0A8_0180, 3'd3, 1'b1);
		push_query(32'hC0A8_0180, 3'd2, 1'b0);
		push_query(32'hC0A8_0201, 3'd2, 1'b1);
		push_write(3'd7, FS_NET, 32'hFFFF_FFFF);
		push_write(3'd7, FS_NETMASK, 32'h0000_0000);

		random_phase(110);
		set_subnets_local(1'b0);
		random_phase(110);
		set_subnets_local(1'b1);
		random_phase(110);
		set_subnets_local(1'b0);
		random_phase(110);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
